### rtl/core/b58_pkg.sv
`timescale 1ns / 1ps
package b58_pkg;

	localparam int DIGIT_BASE = 58;
	localparam int MAX_OUT    = 64;
	localparam int HI_W       = 14;
	localparam int APB_AW     = 3;

	localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;
	localparam logic [7:0] LIMIT_RESET      = 8'd255;
	localparam logic [7:0] CHAR_ONE         = 8'h31;
	localparam logic [7:0] CHAR_NUL         = 8'h00;

	localparam logic [8*DIGIT_BASE-1:0] ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	// 256*d split into {quotient, remainder} by the digit base, for d below the base
	function automatic logic [HI_W*64-1:0] build_hi_tab();
		logic [HI_W*64-1:0] t;
		int v;
		t = '0;
		for (int d = 0; d < DIGIT_BASE; d++) begin
			v = d * 256;
			t[HI_W*d +: HI_W] = {8'(v / DIGIT_BASE), 6'(v % DIGIT_BASE)};
		end
		return t;
	endfunction

	localparam logic [HI_W*64-1:0] HI_TAB = build_hi_tab();

	function automatic logic [7:0] b58_char(input logic [5:0] d);
		logic [7:0] c;
		c = CHAR_NUL;
		if (int'(d) < DIGIT_BASE) begin
			c = ALPHABET[8*(DIGIT_BASE-1-int'(d)) +: 8];
		end
		return c;
	endfunction

	typedef struct packed {
		logic accept;
		logic fold;
		logic load_emit;
		logic emit_err;
		logic emit_zero;
		logic emit_digit;
		logic clear;
	} b58_cmd_t;

	typedef struct packed {
		logic fold_needed;
		logic fold_done;
		logic err;
		logic has_zeros;
		logic has_digits;
		logic zero_last;
		logic digit_done;
		logic slot_free;
	} b58_stat_t;

endpackage

### rtl/core/b58_byte_if.sv
`timescale 1ns / 1ps
interface b58_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/b58_char_if.sv
`timescale 1ns / 1ps
interface b58_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;
	logic       error_flag;

	modport source(output valid, output out_char, output last_char, output error_flag,
		input ready);
	modport sink(input valid, input out_char, input last_char, input error_flag,
		output ready);
endinterface

### rtl/core/base58_encoder_core.sv
`timescale 1ns / 1ps
// Streaming base58 encoder.
// din takes one byte word per transfer (data_byte, last_byte on the final
// byte). dout gives one character word per transfer (out_char, last_char on
// the final character, error_flag on the single error word that replaces the
// string on overflow of MAX_BYTES, the digit store, output_limit or MAX_OUT).
// output_limit sits at APB address 0; write it only while the block is idle.
// Each byte is accepted, then folded into the digit store one live base-58
// digit at a time until the live digits and the carry are spent or the last
// of the DIGIT_SLOTS slots is reached, the pace set by the single digit memory
// port and the carry passed from digit to digit; leading zero and dropped bytes are only accepted.
// After the final byte, a check state, then one character per cycle while
// the receiver is ready, with a memory read before the first significant digit.
// dout is registered: a stalled receiver holds the current word and pauses the
// character stream, while a new byte can still be taken once emission is done.
// Reset sets output_limit to 255 and leaves the block idle with an empty
// string; the digit memory needs no clearing pass.
module base58_encoder_core #(
	parameter int MAX_BYTES   = 32,
	parameter int DIGIT_SLOTS = 46
) (
	input  logic                       clk,
	input  logic                       arst_n,
	b58_byte_if.sink                   din,
	b58_char_if.source                 dout,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [b58_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import b58_pkg::*;

	b58_cmd_t   cmd;
	b58_stat_t  st;
	logic [7:0] output_limit;
	logic       in_ready;

	assign din.ready = in_ready;

	b58_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.output_limit (output_limit)
	);

	b58_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_last  (din.last_byte),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	b58_dpath #(
		.MAX_BYTES   (MAX_BYTES),
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.data_byte    (din.data_byte),
		.output_limit (output_limit),
		.dout         (dout)
	);

endmodule

### rtl/core/b58_cfg.sv
`timescale 1ns / 1ps
module b58_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [b58_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [7:0]                  output_limit
);
	import b58_pkg::*;

	logic [7:0] limit_q;
	logic       sel_limit;

	assign sel_limit    = (paddr[APB_AW-1:2] == REG_OUTPUT_LIMIT);
	assign pready       = 1'b1;
	assign output_limit = limit_q;
	assign prdata       = sel_limit ? {24'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			limit_q <= pwdata[7:0];
		end
	end

endmodule

### rtl/core/b58_ctrl.sv
`timescale 1ns / 1ps
module b58_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  b58_pkg::b58_stat_t st,
	output b58_pkg::b58_cmd_t  cmd
);
	import b58_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_FOLD   = 6'b000010,
		S_CHECK  = 6'b000100,
		S_ERR    = 6'b001000,
		S_ZEROS  = 6'b010000,
		S_DIGITS = 6'b100000
	} b58_state_t;

	b58_state_t state_q, state_d;
	logic       last_q, last_d;

	always_comb begin
		state_d  = state_q;
		last_d   = last_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					last_d = in_last;
					if (st.fold_needed) begin
						state_d = S_FOLD;
					end else if (in_last) begin
						state_d = S_CHECK;
					end
				end
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (st.fold_done) begin
					state_d = last_q ? S_CHECK : S_IDLE;
				end
			end
			S_CHECK: begin
				cmd.load_emit = 1'b1;
				if (st.err) begin
					state_d = S_ERR;
				end else if (st.has_zeros) begin
					state_d = S_ZEROS;
				end else if (st.has_digits) begin
					state_d = S_DIGITS;
				end else begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_ERR: begin
				cmd.emit_err = 1'b1;
				if (st.slot_free) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_ZEROS: begin
				cmd.emit_zero = 1'b1;
				if (st.slot_free && st.zero_last) begin
					if (st.has_digits) begin
						state_d = S_DIGITS;
					end else begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
				end
			end
			S_DIGITS: begin
				cmd.emit_digit = 1'b1;
				if (st.digit_done) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

endmodule

### rtl/core/b58_dpath.sv
`timescale 1ns / 1ps
module b58_dpath #(
	parameter int MAX_BYTES   = 32,
	parameter int DIGIT_SLOTS = 46
) (
	input  logic               clk,
	input  logic               arst_n,
	input  b58_pkg::b58_cmd_t  cmd,
	output b58_pkg::b58_stat_t st,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         output_limit,
	b58_char_if.source         dout
);
	import b58_pkg::*;

	localparam int AW = $clog2(DIGIT_SLOTS);
	localparam int HW = $clog2(DIGIT_SLOTS + 1);
	localparam int BW = $clog2(MAX_BYTES + 1);
	localparam int TW = $clog2(MAX_BYTES + DIGIT_SLOTS + 2);
	localparam int CW = (TW > 8) ? TW + 1 : 9;

	logic [5:0]    mem [DIGIT_SLOTS];
	logic [5:0]    rdata_q;
	logic          mem_re;
	logic [AW-1:0] raddr;

	logic [BW-1:0] byte_count_q, zero_count_q, zleft_q;
	logic          lead_q, ovf_q, has_nz_q, rd_pend_q;
	logic [HW-1:0] hm_q;
	logic [AW-1:0] k_q, top_q, ptr_q;
	logic [7:0]    carry_q;

	logic          out_valid_q, out_last_q, out_err_q;
	logic [7:0]    out_char_q;

	logic          in_range, cont, k_end, slot_free, push;
	logic [5:0]    d, nd;
	logic [7:0]    qd;
	logic [5:0]    rd;
	logic [8:0]    x, sub;
	logic [2:0]    qx;
	logic [7:0]    nc;
	logic [HW-1:0] digits;
	logic [CW-1:0] total;
	logic          byte_ok, zero_lead;
	logic [7:0]    push_char;
	logic          push_last, push_err;

	assign byte_ok   = byte_count_q < BW'(MAX_BYTES);
	assign zero_lead = lead_q && (data_byte == 8'd0);

	// one digit of store*256+carry per cycle
	always_comb begin
		in_range = HW'(k_q) < hm_q;
		cont     = in_range || (carry_q != 8'd0);
		k_end    = (k_q == AW'(DIGIT_SLOTS - 1));
		d        = in_range ? rdata_q : 6'd0;
		{qd, rd} = HI_TAB[HI_W*d +: HI_W];
		x        = 9'(rd) + 9'(carry_q);
		qx       = 3'd0;
		sub      = 9'd0;
		for (int i = 1; i <= 5; i++) begin
			if (x >= 9'(i * DIGIT_BASE)) begin
				qx  = 3'(i);
				sub = 9'(i * DIGIT_BASE);
			end
		end
		nd = 6'(x - sub);
		nc = 8'(9'(qd) + 9'(qx));
	end

	assign digits = has_nz_q ? HW'(top_q) + HW'(1) : HW'(0);
	assign total  = CW'(zero_count_q) + CW'(digits);

	assign slot_free = !out_valid_q || dout.ready;

	always_comb begin
		st             = '0;
		st.fold_needed = byte_ok && !zero_lead;
		st.fold_done   = !cont || k_end;
		st.err         = ovf_q || (total + CW'(1) > CW'(output_limit)) || (total > CW'(MAX_OUT));
		st.has_zeros   = zero_count_q != '0;
		st.has_digits  = has_nz_q;
		st.zero_last   = zleft_q == BW'(1);
		st.digit_done  = cmd.emit_digit && rd_pend_q && slot_free && (ptr_q == '0);
		st.slot_free   = slot_free;
	end

	always_comb begin
		mem_re = 1'b0;
		raddr  = '0;
		if (cmd.accept && byte_ok && !zero_lead) begin
			mem_re = 1'b1;
		end else if (cmd.fold && cont && !k_end) begin
			mem_re = 1'b1;
			raddr  = k_q + AW'(1);
		end else if (cmd.emit_digit) begin
			if (!rd_pend_q) begin
				mem_re = 1'b1;
				raddr  = ptr_q;
			end else if (slot_free && ptr_q != '0) begin
				mem_re = 1'b1;
				raddr  = ptr_q - AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fold && cont) begin
			mem[k_q] <= nd;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			zero_count_q <= '0;
			lead_q       <= 1'b1;
			hm_q         <= '0;
			ovf_q        <= 1'b0;
			has_nz_q     <= 1'b0;
			rd_pend_q    <= 1'b0;
		end else if (cmd.clear) begin
			byte_count_q <= '0;
			zero_count_q <= '0;
			lead_q       <= 1'b1;
			hm_q         <= '0;
			ovf_q        <= 1'b0;
			has_nz_q     <= 1'b0;
			rd_pend_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (!byte_ok) begin
					ovf_q <= 1'b1;
				end else begin
					byte_count_q <= byte_count_q + BW'(1);
					if (zero_lead) begin
						zero_count_q <= zero_count_q + BW'(1);
					end else begin
						lead_q   <= 1'b0;
						has_nz_q <= 1'b0;
					end
				end
			end
			if (cmd.fold) begin
				if (cont && nd != 6'd0) begin
					has_nz_q <= 1'b1;
				end
				if (!cont) begin
					hm_q <= HW'(k_q);
				end else if (k_end) begin
					hm_q <= HW'(k_q) + HW'(1);
					if (nc != 8'd0) begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (cmd.load_emit) begin
				rd_pend_q <= 1'b0;
			end else if (cmd.emit_digit) begin
				if (!rd_pend_q) begin
					rd_pend_q <= 1'b1;
				end else if (slot_free && ptr_q == '0) begin
					rd_pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && byte_ok && !zero_lead) begin
			carry_q <= data_byte;
			k_q     <= '0;
		end else if (cmd.fold && cont) begin
			carry_q <= nc;
			k_q     <= k_q + AW'(1);
			if (nd != 6'd0) begin
				top_q <= k_q;
			end
		end
		if (cmd.load_emit) begin
			zleft_q <= zero_count_q;
			ptr_q   <= top_q;
		end else begin
			if (cmd.emit_zero && slot_free) begin
				zleft_q <= zleft_q - BW'(1);
			end
			if (cmd.emit_digit && rd_pend_q && slot_free && ptr_q != '0) begin
				ptr_q <= ptr_q - AW'(1);
			end
		end
	end

	always_comb begin
		push      = 1'b0;
		push_char = CHAR_NUL;
		push_last = 1'b0;
		push_err  = 1'b0;
		if (cmd.emit_err) begin
			push      = slot_free;
			push_last = 1'b1;
			push_err  = 1'b1;
		end else if (cmd.emit_zero) begin
			push      = slot_free;
			push_char = CHAR_ONE;
			push_last = (zleft_q == BW'(1)) && !has_nz_q;
		end else if (cmd.emit_digit) begin
			push      = slot_free && rd_pend_q;
			push_char = b58_char(rdata_q);
			push_last = ptr_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_char_q <= push_char;
			out_last_q <= push_last;
			out_err_q  <= push_err;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.out_char   = out_char_q;
	assign dout.last_char  = out_last_q;
	assign dout.error_flag = out_err_q;

endmodule
